>>> rtl/format_string_to_ascii_stream_core_defines.svh
// ----------------------------------------------------------------------------
// format_string_to_ascii_stream_core_defines
// Assertion macros used by the format streamer core.
// ----------------------------------------------------------------------------
`ifndef FORMAT_STRING_TO_ASCII_STREAM_CORE_DEFINES_SVH
`define FORMAT_STRING_TO_ASCII_STREAM_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define FSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define FSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, character codes and helpers for the format string streamer.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int ARG_W      = 64;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 20;
  localparam int DIG_W      = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(ARG_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(ARG_W - 1);
  localparam logic [DIG_CNT_W-1:0] DIG_FULL   = DIG_CNT_W'(NUM_DIGITS);
  localparam logic [DIG_CNT_W-1:0] DIG_ONE    = DIG_CNT_W'(1);
  localparam int                   HEX_PAD_W  = DIG_W - ARG_W;

  // Format characters
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LOW_D   = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOW_C   = 8'h63;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA   = 8'h37;  // 'A' minus ten

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EMIT,
    ST_BYTE
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DEC,
    OP_LOAD_HEX,
    OP_DABBLE,
    OP_SHIFT
  } dig_op_t;

  typedef struct packed {
    dig_op_t op;
  } dig_ctrl_t;

  typedef struct packed {
    logic [3:0] top_digit;
  } dig_stat_t;

  // Map one digit 0..15 to its uppercase ASCII code
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0, d};
    return (d < 4'd10) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
  endfunction

endpackage

>>> rtl/fsc_if.sv
// ----------------------------------------------------------------------------
// fsc_if
// Valid/ready channels for format beats and emitted characters.
// ----------------------------------------------------------------------------
interface fsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsc_pkg::CHAR_W-1:0]    fmt_char;
  logic [fsc_pkg::ARG_W-1:0]     arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface fsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsc_pkg::CHAR_W-1:0]    out_char;
  logic                          last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> rtl/fsc_digit_unit.sv
// ----------------------------------------------------------------------------
// fsc_digit_unit
// Shared shift/add-3 unit: loads a hex argument as digits or converts binary
// to BCD one bit per cycle, and shifts digits out of the top, most significant first.
// ----------------------------------------------------------------------------
module fsc_digit_unit (
  input  logic                       clk,
  input  fsc_pkg::dig_ctrl_t         ctrl,
  input  logic [fsc_pkg::ARG_W-1:0]  arg,
  output fsc_pkg::dig_stat_t         stat
);

  logic [fsc_pkg::ARG_W-1:0] bin_r, bin_nxt;
  logic [fsc_pkg::DIG_W-1:0] bcd_r, bcd_nxt;
  logic [fsc_pkg::DIG_W-1:0] adj;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < fsc_pkg::NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                 : bcd_r[i*4 +: 4];
    end
  end

  // Select the operation
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    case (ctrl.op)
      fsc_pkg::OP_LOAD_DEC: begin
        bin_nxt = arg;
        bcd_nxt = '0;
      end
      fsc_pkg::OP_LOAD_HEX: begin
        bcd_nxt = {{fsc_pkg::HEX_PAD_W{1'b0}}, arg};
      end
      fsc_pkg::OP_DABBLE: begin
        bcd_nxt = {adj[fsc_pkg::DIG_W-2:0], bin_r[fsc_pkg::ARG_W-1]};
        bin_nxt = {bin_r[fsc_pkg::ARG_W-2:0], 1'b0};
      end
      fsc_pkg::OP_SHIFT: begin
        bcd_nxt = {bcd_r[fsc_pkg::DIG_W-5:0], 4'b0};
      end
      default: begin
        bin_nxt = bin_r;
        bcd_nxt = bcd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.top_digit = bcd_r[fsc_pkg::DIG_W-1 -: 4];

endmodule

>>> rtl/format_string_to_ascii_stream_core.sv
// ----------------------------------------------------------------------------
// format_string_to_ascii_stream_core
// Streams the ASCII output of a printf subset (%d, %x, %X, %c), one
// character per beat with a last flag on the final character of a run.
// ----------------------------------------------------------------------------
// Plain byte or %c: the beat is accepted, then the character is loaded into the output register once it is free.
// %x/%X: leading-zero skip plus emit, one digit per cycle while the output register is free.
// %d: shift/add-3 over every argument bit through the shared digit unit, then the %x/%X emit.
// Next beat is taken once the last character sits in the output register.
// Synchronous active-low reset clears the sequencer, pending flag, output valid.
// ----------------------------------------------------------------------------
`include "format_string_to_ascii_stream_core_defines.svh"

module format_string_to_ascii_stream_core (
  input  logic       clk,
  input  logic       rst_n,
  fsc_in_if.sink     in_bus,
  fsc_out_if.source  out_bus
);

  fsc_pkg::state_t                   state_r, state_nxt;
  logic                              pend_r, pend_nxt;
  logic                              started_r, started_nxt;
  logic [fsc_pkg::BIT_CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [fsc_pkg::DIG_CNT_W-1:0]     dig_cnt_r, dig_cnt_nxt;
  logic [fsc_pkg::CHAR_W-1:0]        byte_r, byte_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [fsc_pkg::CHAR_W-1:0]        out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;
  logic                              slot_free;
  logic                              out_load;
  logic                              in_acc;
  fsc_pkg::dig_ctrl_t                dctrl;
  fsc_pkg::dig_stat_t                dstat;

  fsc_digit_unit u_digit (
    .clk  (clk),
    .ctrl (dctrl),
    .arg  (in_bus.arg_value),
    .stat (dstat)
  );

  assign in_bus.ready = (state_r == fsc_pkg::ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign slot_free    = !out_valid_r || out_bus.ready;

  // Sequencer: decode a beat, run the digit unit, emit characters
  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    started_nxt  = started_r;
    bit_cnt_nxt  = bit_cnt_r;
    dig_cnt_nxt  = dig_cnt_r;
    byte_nxt     = byte_r;
    dctrl.op     = fsc_pkg::OP_HOLD;
    out_load     = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    case (state_r)
      fsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (in_bus.fmt_char == fsc_pkg::CH_LOW_D) begin
              dctrl.op    = fsc_pkg::OP_LOAD_DEC;
              bit_cnt_nxt = '0;
              state_nxt   = fsc_pkg::ST_DABBLE;
            end else if (in_bus.fmt_char == fsc_pkg::CH_LOW_X ||
                         in_bus.fmt_char == fsc_pkg::CH_UP_X) begin
              dctrl.op    = fsc_pkg::OP_LOAD_HEX;
              dig_cnt_nxt = fsc_pkg::DIG_FULL;
              started_nxt = 1'b0;
              state_nxt   = fsc_pkg::ST_EMIT;
            end else if (in_bus.fmt_char == fsc_pkg::CH_LOW_C) begin
              byte_nxt  = in_bus.arg_value[fsc_pkg::CHAR_W-1:0];
              state_nxt = fsc_pkg::ST_BYTE;
            end
          end else if (in_bus.fmt_char == fsc_pkg::CH_PERCENT) begin
            pend_nxt = 1'b1;
          end else begin
            byte_nxt  = in_bus.fmt_char;
            state_nxt = fsc_pkg::ST_BYTE;
          end
        end
      end
      fsc_pkg::ST_DABBLE: begin
        dctrl.op    = fsc_pkg::OP_DABBLE;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == fsc_pkg::BIT_LAST) begin
          dig_cnt_nxt = fsc_pkg::DIG_FULL;
          started_nxt = 1'b0;
          state_nxt   = fsc_pkg::ST_EMIT;
        end
      end
      fsc_pkg::ST_EMIT: begin
        if (!started_r && dstat.top_digit == 4'd0 && dig_cnt_r != fsc_pkg::DIG_ONE) begin
          // drop a leading zero
          dctrl.op    = fsc_pkg::OP_SHIFT;
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else if (slot_free) begin
          dctrl.op     = fsc_pkg::OP_SHIFT;
          out_load     = 1'b1;
          out_char_nxt = fsc_pkg::digit_ascii(dstat.top_digit);
          out_last_nxt = (dig_cnt_r == fsc_pkg::DIG_ONE);
          started_nxt  = 1'b1;
          dig_cnt_nxt  = dig_cnt_r - 1'b1;
          if (dig_cnt_r == fsc_pkg::DIG_ONE) begin
            state_nxt = fsc_pkg::ST_IDLE;
          end
        end
      end
      fsc_pkg::ST_BYTE: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = byte_r;
          out_last_nxt = 1'b1;
          state_nxt    = fsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register valid: set on load, clear once taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsc_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      started_r   <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      started_r   <= started_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds, no reset
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.out_char = out_char_r;
  assign out_bus.last     = out_last_r;

  // Assertions
  `FSC_ASSERT(a_pct_arms, (in_acc && !pend_r && in_bus.fmt_char == fsc_pkg::CH_PERCENT) |=> (pend_r && state_r == fsc_pkg::ST_IDLE), "percent beat did not arm pending flag")
  `FSC_ASSERT(a_dig_cnt_range, dig_cnt_r <= fsc_pkg::DIG_FULL, "digit count beyond digit capacity")
  `FSC_ASSERT(a_last_ends_run, (out_load && out_last_nxt) |=> (state_r == fsc_pkg::ST_IDLE && out_valid_r), "last character did not end the run")
  `FSC_ASSERT(a_dabble_done, (state_r == fsc_pkg::ST_DABBLE && bit_cnt_r == fsc_pkg::BIT_LAST) |=> (state_r == fsc_pkg::ST_EMIT && dig_cnt_r == fsc_pkg::DIG_FULL), "conversion did not hand over to emit")

endmodule
